/* sv/mlac_pkg.sv */
package mlac_pkg;

   localparam int CHANNELS_DEF = 16;
   localparam logic [31:0] LIMIT_OFF = 32'hFFFF_FFFF;
   // event queue depth, kept a power of two so the pointers wrap on their own
   localparam int EVQ_DEPTH = 4;

   localparam logic ALARM_OVER  = 1'b0;
   localparam logic ALARM_UNDER = 1'b1;

   typedef struct packed {
      logic [3:0]  channel;
      logic [31:0] sample_value;
      logic [31:0] over_limit;
      logic [30:0] over_margin;
      logic [31:0] under_limit;
      logic [30:0] under_margin;
      logic [6:0]  confirm_count;
   } req_payload_type;

   typedef struct packed {
      logic [3:0] event_channel;
      logic       alarm_kind;
      logic       raised;
      logic       last_event;
   } rsp_payload_type;

   typedef struct packed {
      logic [7:0] count;
      logic       active;
   } alarm_state_type;

   localparam int ALARM_W = $bits(alarm_state_type);

   typedef struct packed {
      alarm_state_type over;
      alarm_state_type under;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic                  wr;
      entry_type             entry;
      logic [1:0]            beats;
      rsp_payload_type [1:0] beat;
   } update_type;

endpackage

/* sv/mlac_chan_if.sv */
interface mlac_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* sv/mlac_ram.sv */
module mlac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* sv/mlac_update.sv */
module mlac_update import mlac_pkg::*; (
   input  logic            enable,
   input  logic            in_range,
   input  req_payload_type req,
   input  entry_type       cur,
   output update_type      upd
);
   function automatic logic [ALARM_W:0] alarm_step(
      input alarm_state_type st,
      input logic            beyond,
      input logic            in_margin,
      input logic [6:0]      cc
   );
      alarm_state_type nx;
      logic            ev;
      logic [7:0]      up;
      logic [7:0]      down;
      up   = {1'b0, cc};
      down = 8'd0 - up;
      nx   = st;
      ev   = 1'b0;
      if (!st.active) begin
         if (beyond) begin
            nx.count = st.count + 8'd1;
            if (nx.count == up) begin
               nx.active = 1'b1;
               ev = 1'b1;
            end
         end else begin
            nx.count = '0;
         end
      end else begin
         if (in_margin) begin
            nx.count = st.count - 8'd1;
            if (nx.count == down) begin
               nx.active = 1'b0;
               ev = 1'b1;
            end
         end else begin
            nx.count = '0;
         end
      end
      return {ev, nx};
   endfunction

   logic              go;
   logic              over_on;
   logic              under_on;
   logic [31:0]       over_diff;
   logic [31:0]       under_diff;
   logic              over_beyond;
   logic              under_beyond;
   logic              over_inside;
   logic              under_inside;
   logic [ALARM_W:0]  over_res;
   logic [ALARM_W:0]  under_res;
   alarm_state_type   over_next;
   alarm_state_type   under_next;
   logic              ev_over;
   logic              ev_under;
   rsp_payload_type   over_beat;
   rsp_payload_type   under_beat;

   assign go       = enable && in_range;
   assign over_on  = (req.over_limit != '0) && (req.over_limit != LIMIT_OFF);
   assign under_on = (req.under_limit != '0) && (req.under_limit != LIMIT_OFF);

   assign over_beyond  = req.sample_value >= req.over_limit;
   assign under_beyond = req.sample_value <= req.under_limit;
   // margin tests use the wrapped difference read as signed
   assign over_diff    = req.over_limit - req.sample_value;
   assign under_diff   = req.sample_value - req.under_limit;
   assign over_inside  = $signed(over_diff) >= $signed({1'b0, req.over_margin});
   assign under_inside = $signed(under_diff) >= $signed({1'b0, req.under_margin});

   assign over_res  = alarm_step(cur.over, over_beyond, over_inside, req.confirm_count);
   assign under_res = alarm_step(cur.under, under_beyond, under_inside, req.confirm_count);

   assign over_next  = (go && over_on) ? over_res[ALARM_W-1:0] : cur.over;
   assign under_next = (go && under_on) ? under_res[ALARM_W-1:0] : cur.under;
   assign ev_over    = go && over_on && over_res[ALARM_W];
   assign ev_under   = go && under_on && under_res[ALARM_W];

   assign over_beat  = '{event_channel: req.channel, alarm_kind: ALARM_OVER,
                         raised: over_next.active, last_event: !ev_under};
   assign under_beat = '{event_channel: req.channel, alarm_kind: ALARM_UNDER,
                         raised: under_next.active, last_event: 1'b1};

   always_comb begin
      upd.wr          = go && (over_on || under_on);
      upd.entry.over  = over_next;
      upd.entry.under = under_next;
      upd.beats       = 2'(ev_over) + 2'(ev_under);
      upd.beat[0]     = ev_over ? over_beat : under_beat;
      upd.beat[1]     = under_beat;
   end
endmodule

/* sv/mlac_evq.sv */
module mlac_evq import mlac_pkg::*; (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [1:0]                      push_n,
   input  rsp_payload_type [1:0]           push_beat,
   output logic [$clog2(EVQ_DEPTH):0]      used,
   mlac_chan_if.source                     rsp_if
);
   localparam int PW = $clog2(EVQ_DEPTH);
   localparam int CW = PW + 1;

   rsp_payload_type mem_ff [EVQ_DEPTH];
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0]   used_ff, used_in;
   logic [PW-1:0]   wr_ptr_next;
   logic            pop;

   assign pop         = rsp_if.valid && rsp_if.ready;
   assign wr_ptr_next = wr_ptr_ff + PW'(1);

   always_comb begin
      rd_ptr_in = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff + PW'(push_n);
      used_in   = used_ff + CW'(push_n) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         used_ff   <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         used_ff   <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push_beat[0];
      end
      if (push_n == 2'd2) begin
         mem_ff[wr_ptr_next] <= push_beat[1];
      end
   end

   assign used           = used_ff;
   assign rsp_if.valid   = used_ff != '0;
   assign rsp_if.payload = mem_ff[rd_ptr_ff];
endmodule

/* sv/multichannel_limit_alarm_confirm.sv */
// Multichannel limit alarm with confirmation count and clearing margin.
// req_if carries one sample beat: channel, value, both limits and margins
// and the confirm count. rsp_if carries alarm events, zero to two beats per
// sample, over alarm first; last_event marks the final beat of a sample.
// csr_write_enable / csr_write_data write alarm_enable; 0 freezes all state.
// A sample in the update stage writes its channel state and pushes its
// event beats as it leaves that stage; the queue output is registered.
// Throughput: one sample per cycle while the queue has room, set by the
// single read-modify-write of the channel state memory (read at accept,
// write on exit, with forwarding for back-to-back same-channel samples).
// Events go into a 4-beat queue. A sample waits in the update stage until
// the queue has room for all of its events; while it waits req_if.ready is
// low, so a stalled receiver backs up into the sample channel.
// Reset: alarm_enable clears, the queue empties and every channel reads as
// idle with zero counts through per-channel valid bits; there is no
// clearing pass, so samples are taken in the first cycle after reset.
module multichannel_limit_alarm_confirm import mlac_pkg::*; #(
   parameter int CHANNELS = CHANNELS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_write_data,
   mlac_chan_if.sink   req_if,
   mlac_chan_if.source rsp_if
);
   localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CW = $clog2(EVQ_DEPTH) + 1;
   localparam int QW = CW + 1;

   logic                  enable_ff;
   logic                  s1_valid_ff, s1_valid_in;
   req_payload_type       s1_req_ff;
   logic [CHANNELS-1:0]   chan_valid_ff;
   logic                  fwd_valid_ff;
   logic [AW-1:0]         fwd_addr_ff;
   entry_type             fwd_data_ff;

   logic                  req_accept;
   logic                  s1_fire;
   logic                  s1_in_range;
   logic [AW+3:0]         req_addr_ext;
   logic [AW+3:0]         s1_addr_ext;
   logic [AW-1:0]         req_addr;
   logic [AW-1:0]         s1_addr;
   logic [ENTRY_W-1:0]    ram_rdata;
   entry_type             cur_entry;
   update_type            upd;
   logic [CW-1:0]         evq_used;
   logic                  room;
   logic [1:0]            push_n;

   assign req_addr_ext = {{AW{1'b0}}, req_if.payload.channel};
   assign s1_addr_ext  = {{AW{1'b0}}, s1_req_ff.channel};
   assign req_addr     = req_addr_ext[AW-1:0];
   assign s1_addr      = s1_addr_ext[AW-1:0];
   assign s1_in_range  = 32'(s1_req_ff.channel) < 32'(CHANNELS);

   assign room        = (QW'(upd.beats) + QW'(evq_used)) <= QW'(EVQ_DEPTH);
   assign s1_fire     = s1_valid_ff && room;
   assign req_if.ready = !s1_valid_ff || s1_fire;
   assign req_accept  = req_if.valid && req_if.ready;
   assign push_n      = s1_fire ? upd.beats : 2'd0;

   // newest write wins over the memory, untouched channels read as zero
   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == s1_addr)) begin
         cur_entry = fwd_data_ff;
      end else if (chan_valid_ff[s1_addr]) begin
         cur_entry = entry_type'(ram_rdata);
      end else begin
         cur_entry = '0;
      end
   end

   always_comb begin
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= 1'b0;
         s1_valid_ff   <= 1'b0;
         chan_valid_ff <= '0;
         fwd_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (csr_write_enable) begin
            enable_ff <= csr_write_data;
         end
         if (s1_fire && upd.wr) begin
            chan_valid_ff[s1_addr] <= 1'b1;
            fwd_valid_ff           <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff <= req_if.payload;
      end
      if (s1_fire && upd.wr) begin
         fwd_addr_ff <= s1_addr;
         fwd_data_ff <= upd.entry;
      end
   end

   mlac_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CHANNELS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (s1_fire && upd.wr),
      .wr_addr (s1_addr),
      .wr_data (upd.entry),
      .rd_en   (req_accept),
      .rd_addr (req_addr),
      .rd_data (ram_rdata)
   );

   mlac_update u_update (
      .enable   (enable_ff),
      .in_range (s1_in_range),
      .req      (s1_req_ff),
      .cur      (cur_entry),
      .upd      (upd)
   );

   mlac_evq u_evq (
      .clock     (clock),
      .reset     (reset),
      .push_n    (push_n),
      .push_beat (upd.beat),
      .used      (evq_used),
      .rsp_if    (rsp_if)
   );

   a_evq_bound: assert property (@(posedge clock) disable iff (reset)
      QW'(evq_used) <= QW'(EVQ_DEPTH))
      else $error("event queue over its depth");

   a_forward: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && upd.wr) |=>
         (!s1_valid_ff || (s1_addr != $past(s1_addr)) || (cur_entry == $past(upd.entry))))
      else $error("back-to-back sample missed the previous channel update");

   a_pair_whole: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.payload.last_event) |-> (evq_used >= CW'(2)))
      else $error("first event beat queued without its last beat");
endmodule
